/* design/qlra_pkg.sv */
// Package for the quality ladder rate adapter.
// Holds the rung table, rung geometry helpers and shared constants; no dependencies.
`default_nettype none
package qlra_pkg;

  localparam int RUNG_NUM = 6;
  localparam logic [15:0] MIN_W = 16'd160;
  localparam logic [15:0] MIN_H = 16'd64;
  localparam logic [7:0] FPS_DEFAULT = 8'd60;
  localparam logic [15:0] PCT_DIVISOR = 16'd100;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAX_W    = 3'd0;
  localparam logic [2:0] REG_MAX_H    = 3'd1;
  localparam logic [2:0] REG_MAX_FPS  = 3'd2;
  localparam logic [2:0] REG_BPP_NUM  = 3'd3;
  localparam logic [2:0] REG_BPP_DEN  = 3'd4;
  localparam logic [2:0] REG_HEADROOM = 3'd5;
  localparam logic [2:0] REG_DWELL    = 3'd6;
  localparam logic [2:0] REG_DWELL_RS = 3'd7;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  fps;
    logic [6:0]  pct;
  } step_t;

  // Table scale percent and frame rate of each rung.
  function automatic logic [6:0] rung_pct(input logic [2:0] idx);
    logic [6:0] p;
    case (idx)
      3'd0, 3'd1, 3'd2: p = 7'd100;
      3'd3:             p = 7'd75;
      default:          p = 7'd50;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] rung_fps(input logic [2:0] idx);
    logic [7:0] f;
    case (idx)
      3'd0:    f = 8'd60;
      3'd1:    f = 8'd30;
      3'd5:    f = 8'd12;
      default: f = 8'd20;
    endcase
    return f;
  endfunction

  // Scale by 100, 75 or 50 percent and round down to even.
  function automatic logic [15:0] scale_even(input logic [15:0] v, input logic [6:0] pct);
    logic [17:0] v3;
    logic [15:0] r;
    v3 = {2'b00, v} * 18'd3;
    case (pct)
      7'd75:   r = v3[17:2];
      7'd50:   r = {1'b0, v[15:1]};
      default: r = v;
    endcase
    return {r[15:1], 1'b0};
  endfunction

  function automatic step_t step_at(input logic [2:0] idx, input logic [15:0] max_w,
                                    input logic [15:0] max_h, input logic [7:0] max_fps);
    step_t s;
    logic [2:0] i;
    logic [7:0] cap;
    logic [7:0] f;
    i = (idx >= 3'(RUNG_NUM)) ? 3'(RUNG_NUM - 1) : idx;
    cap = (max_fps == 8'd0) ? FPS_DEFAULT : max_fps;
    f = rung_fps(i);
    s.pct = rung_pct(i);
    s.w = scale_even(max_w, s.pct);
    s.h = scale_even(max_h, s.pct);
    s.fps = (f < cap) ? f : cap;
    return s;
  endfunction

endpackage
`default_nettype wire

/* design/qlra_mul.sv */
// Shared registered multiplier of the rate adapter.
// Depends on nothing; product appears in the cycle after the operands.
`default_nettype none
module qlra_mul (
  input  wire logic        clk,
  input  wire logic [39:0] a,
  input  wire logic [15:0] b,
  output logic      [55:0] prod
);

  // One product per cycle, registered before any further use.
  always_ff @(posedge clk) begin
    prod <= {16'd0, a} * {40'd0, b};
  end

endmodule
`default_nettype wire

/* design/qlra_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; done pulses at the end of each division.
`default_nettype none
module qlra_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [55:0] dividend,
  input  wire logic [15:0] divisor,
  output logic      [55:0] quo,
  output logic             done
);

  logic        busy;
  logic [5:0]  cnt;
  logic [15:0] rem;
  logic [15:0] dsr;
  logic [16:0] trial;
  logic        ge;

  assign trial = {rem, quo[55]};
  assign ge = trial >= {1'b0, dsr};

  // Control: run for one cycle per dividend bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd55;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit, subtract when it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? 16'(trial - {1'b0, dsr}) : trial[15:0];
      quo <= {quo[54:0], ge};
    end
  end

endmodule
`default_nettype wire

/* design/quality_ladder_rate_adapter_unit.sv */
// Quality ladder rate adapter: picks a video rung from a bitrate update.
// Depends on qlra_pkg, qlra_mul and qlra_div.
//
// Usage: an item (bitrate_bps, now_us) enters on in_valid while in_stall is
// low. Each item yields exactly one result (changed, rung_index and the
// rung's frame_width, frame_height, frame_rate, scale_pct) on out_valid,
// held until out_stall is low. Configuration registers are written through
// cfg_write, cfg_index and cfg_data while the block is idle.
// Sequence: each candidate rung's need costs 3 multiplies, a divider start
// and a wait on the shared divider. The search visits one to six rungs.
// Then comes the decision, and a step-up check adds one more need plus a
// multiply by the headroom and a compare. The result is loaded last. One
// item is worked on at a time; in_stall is high from acceptance until the
// result is loaded.
// Reset clears the rung state and loads the register defaults. When the
// receiver stalls, the finished result is held, the next item is taken and
// worked on, and its result waits until the held one has been accepted.
`default_nettype none
module quality_ladder_rate_adapter_unit
  import qlra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] bitrate_bps,
  input  wire logic [63:0] now_us,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             changed,
  output logic      [2:0]  rung_index,
  output logic      [15:0] frame_width,
  output logic      [15:0] frame_height,
  output logic      [7:0]  frame_rate,
  output logic      [6:0]  scale_pct,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_M1    = 4'd1;
  localparam logic [3:0] S_M2    = 4'd2;
  localparam logic [3:0] S_M3    = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_DWAIT = 4'd5;
  localparam logic [3:0] S_DEC   = 4'd6;
  localparam logic [3:0] S_M4    = 4'd7;
  localparam logic [3:0] S_HCHK  = 4'd8;
  localparam logic [3:0] S_HOLD  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  // Configuration registers.
  logic [15:0] max_width, max_height, bpp_num, bpp_den;
  logic [7:0]  max_fps, headroom_pct;
  logic [31:0] dwell_us, dwell_resize_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width       <= 16'd1920;
      max_height      <= 16'd1080;
      max_fps         <= 8'd60;
      bpp_num         <= 16'd1;
      bpp_den         <= 16'd10;
      headroom_pct    <= 8'd120;
      dwell_us        <= 32'd2000000;
      dwell_resize_us <= 32'd5000000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_W:    max_width       <= cfg_data[15:0];
        REG_MAX_H:    max_height      <= cfg_data[15:0];
        REG_MAX_FPS:  max_fps         <= cfg_data[7:0];
        REG_BPP_NUM:  bpp_num         <= cfg_data[15:0];
        REG_BPP_DEN:  bpp_den         <= cfg_data[15:0];
        REG_HEADROOM: headroom_pct    <= cfg_data[7:0];
        REG_DWELL:    dwell_us        <= cfg_data;
        REG_DWELL_RS: dwell_resize_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // Usable rung count: skip duplicates, stop below the minimum size.
  logic [2:0] count_now;
  always_comb begin
    step_t prev;
    step_t s;
    logic  stop;
    prev = step_at(3'd0, max_width, max_height, max_fps);
    count_now = 3'd1;
    stop = 1'b0;
    for (int i = 1; i < RUNG_NUM; i++) begin
      s = step_at(3'(i), max_width, max_height, max_fps);
      if (!stop && s != prev) begin
        if (s.w < MIN_W || s.h < MIN_H) begin
          stop = 1'b1;
        end else begin
          prev = s;
          count_now = count_now + 3'd1;
        end
      end
    end
  end

  // Sequencer and rung state.
  logic [3:0]  state;
  logic [2:0]  idx, cnt, want, cur;
  logic        hr_phase;
  logic        chg;
  logic [31:0] bps;
  logic [63:0] now;
  logic [63:0] last_change, up_since;

  step_t       st_idx, st_cur, st_next;
  logic [39:0] mul_a;
  logic [15:0] mul_b;
  logic [55:0] prod, quo;
  logic        div_start, div_done;
  logic [15:0] div_dsr;
  logic [31:0] need;
  logic [63:0] dwell;
  logic [39:0] bps_x100;
  logic        below_need;

  assign st_idx  = step_at(idx, max_width, max_height, max_fps);
  assign st_cur  = step_at(cur, max_width, max_height, max_fps);
  assign st_next = step_at(3'(cur - 3'd1), max_width, max_height, max_fps);
  assign need    = quo[31:0];
  assign dwell   = (st_next.w != st_cur.w || st_next.h != st_cur.h) ?
                   {32'd0, dwell_resize_us} : {32'd0, dwell_us};

  // The bitrate is below need * headroom / 100 (rounded down) exactly when
  // 100 * (bitrate + 1) does not exceed need * headroom.
  assign bps_x100   = 40'(PCT_DIVISOR) * ({8'd0, bps} + 40'd1);
  assign below_need = {16'd0, bps_x100} <= prod;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      S_M1:    begin mul_a = {24'd0, st_idx.w}; mul_b = st_idx.h;         end
      S_M2:    begin mul_a = prod[39:0];        mul_b = {8'd0, st_idx.fps}; end
      S_M3:    begin mul_a = prod[39:0];        mul_b = bpp_num;          end
      default: begin mul_a = {8'd0, need};      mul_b = {8'd0, headroom_pct}; end
    endcase
  end

  assign div_start = (state == S_DIV);
  assign div_dsr   = (bpp_den == 16'd0) ? 16'd1 : bpp_den;

  qlra_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  qlra_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod),
    .divisor (div_dsr),
    .quo     (quo),
    .done    (div_done)
  );

  assign in_stall = (state != S_IDLE);

  // Control flow: search for the best rung, then decide and maybe step up.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur         <= '0;
      last_change <= '0;
      up_since    <= '0;
      out_valid   <= 1'b0;
      hr_phase    <= 1'b0;
    end else begin
      // A result that has been taken is dropped unless a new one is loaded.
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            bps      <= bitrate_bps;
            now      <= now_us;
            idx      <= '0;
            cnt      <= count_now;
            hr_phase <= 1'b0;
            chg      <= 1'b0;
            state    <= S_M1;
          end
        end
        S_M1:  state <= S_M2;
        S_M2:  state <= S_M3;
        S_M3:  state <= S_DIV;
        S_DIV: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            if (hr_phase) begin
              state <= S_M4;
            end else if (bps >= need) begin
              want  <= idx;
              state <= S_DEC;
            end else if (idx == cnt - 3'd1) begin
              want  <= idx;
              state <= S_DEC;
            end else begin
              idx   <= idx + 3'd1;
              state <= S_M1;
            end
          end
        end
        S_DEC: begin
          if (want > cur) begin
            cur         <= want;
            last_change <= now;
            up_since    <= '0;
            chg         <= 1'b1;
            state       <= S_FIN;
          end else if (cur == 3'd0) begin
            up_since <= '0;
            state    <= S_FIN;
          end else begin
            idx      <= cur - 3'd1;
            hr_phase <= 1'b1;
            state    <= S_M1;
          end
        end
        S_M4:  state <= S_HCHK;
        // Hold check against the next better rung's need times the headroom.
        S_HCHK: begin
          hr_phase <= 1'b0;
          state    <= S_FIN;
          if (below_need) begin
            up_since <= '0;
          end else if (up_since == 64'd0) begin
            up_since <= now;
          end else if ((now - up_since) >= dwell && (now - last_change) >= dwell) begin
            cur         <= cur - 3'd1;
            last_change <= now;
            up_since    <= '0;
            chg         <= 1'b1;
          end
        end
        S_HOLD: ;
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            changed      <= chg;
            rung_index   <= cur;
            frame_width  <= st_cur.w;
            frame_height <= st_cur.h;
            frame_rate   <= st_cur.fps;
            scale_pct    <= st_cur.pct;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rung_range: assert property (@(posedge clk) disable iff (rst)
    cur < 3'(RUNG_NUM))
    else $error("current rung out of range");
  a_out_rung: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rung_index < 3'(RUNG_NUM))
    else $error("result rung out of range");
  a_div_issue: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == S_DWAIT)
    else $error("divider started outside the wait sequence");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for quality_ladder_rate_adapter_unit: directed and random bitrate updates
// checked against a built-in rung predictor. Depends on qlra_pkg and the unit RTL.
`default_nettype none
module tb
  import qlra_pkg::*;
;

  localparam int HALF = 6;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES = 3000;
  localparam int ITEMS_PER_PHASE = 306;

  typedef struct packed {
    logic [31:0] bps;
    logic [63:0] now;
  } update_t;

  typedef struct packed {
    logic        chg;
    logic [2:0]  idx;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  fps;
    logic [6:0]  pct;
  } rung_out_t;

  typedef struct {
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] fps;
    logic [31:0] pct;
  } geom_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] bitrate_bps = '0;
  logic [63:0] now_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic changed;
  logic [2:0] rung_index;
  logic [15:0] frame_width;
  logic [15:0] frame_height;
  logic [7:0] frame_rate;
  logic [6:0] scale_pct;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  quality_ladder_rate_adapter_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .bitrate_bps(bitrate_bps), .now_us(now_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .changed(changed), .rung_index(rung_index),
    .frame_width(frame_width), .frame_height(frame_height),
    .frame_rate(frame_rate), .scale_pct(scale_pct),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #HALF clk = ~clk;

  // Register copy and rung state of the predictor.
  logic [15:0] r_w = 16'd1920, r_h = 16'd1080, r_num = 16'd1, r_den = 16'd10;
  logic [7:0] r_fps = 8'd60, r_head = 8'd120;
  logic [31:0] r_dwell = 32'd2000000, r_dwell_rs = 32'd5000000;
  int unsigned cur_rung = 0;
  logic [63:0] last_change = '0;
  logic [63:0] up_since = '0;

  update_t pending_updates[$];
  rung_out_t expected_rungs[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic in_acc = 1'b0;
  logic hold_go = 1'b0;
  int unsigned hold_left = 0;
  logic [63:0] clock_us = 64'd10;

  function automatic geom_t rung_geom(int unsigned i);
    geom_t g;
    logic [31:0] cap;
    logic [31:0] tab_fps;
    cap = (r_fps != 0) ? 32'(r_fps) : 32'd60;
    if (i > 5) i = 5;
    case (i)
      0: begin g.pct = 100; tab_fps = 60; end
      1: begin g.pct = 100; tab_fps = 30; end
      2: begin g.pct = 100; tab_fps = 20; end
      3: begin g.pct = 75; tab_fps = 20; end
      4: begin g.pct = 50; tab_fps = 20; end
      default: begin g.pct = 50; tab_fps = 12; end
    endcase
    g.w = ((32'(r_w) * g.pct) / 100) & ~32'd1;
    g.h = ((32'(r_h) * g.pct) / 100) & ~32'd1;
    g.fps = (tab_fps < cap) ? tab_fps : cap;
    return g;
  endfunction

  // Distinct rungs down to the smallest size still at least 160x64.
  function automatic int unsigned usable_rungs();
    geom_t prev;
    geom_t g;
    int unsigned n;
    prev = rung_geom(0);
    n = 1;
    for (int unsigned i = 1; i < 6; i++) begin
      g = rung_geom(i);
      if (g.w == prev.w && g.h == prev.h && g.fps == prev.fps && g.pct == prev.pct) continue;
      if (g.w < 160 || g.h < 64) break;
      prev = g;
      n++;
    end
    return n;
  endfunction

  // Bits per second that a rung needs, truncated to 32 bits.
  function automatic logic [31:0] rung_need(int unsigned i);
    geom_t g;
    logic [63:0] px;
    logic [63:0] den;
    g = rung_geom(i);
    den = (r_den != 0) ? 64'(r_den) : 64'd1;
    px = 64'(g.w) * 64'(g.h) * 64'(g.fps);
    return 32'((px * 64'(r_num)) / den);
  endfunction

  function automatic int unsigned affordable_rung(logic [31:0] bps);
    int unsigned n;
    n = usable_rungs();
    for (int unsigned i = 0; i < n; i++)
      if (bps >= rung_need(i)) return i;
    return n - 1;
  endfunction

  // Advances the rung state by one update and returns the result it should give.
  function automatic rung_out_t next_rung(logic [31:0] bps, logic [63:0] now);
    rung_out_t r;
    int unsigned want;
    int unsigned up;
    logic [63:0] need;
    logic [63:0] dwell;
    geom_t cand;
    geom_t cur;
    r.chg = 1'b0;
    want = affordable_rung(bps);
    if (want > cur_rung) begin
      cur_rung = want;
      last_change = now;
      up_since = '0;
      r.chg = 1'b1;
    end else if (cur_rung == 0) begin
      up_since = '0;
    end else begin
      up = cur_rung - 1;
      need = (64'(rung_need(up)) * 64'(r_head)) / 100;
      if (64'(bps) < need) begin
        up_since = '0;
      end else if (up_since == 0) begin
        up_since = now;
      end else begin
        cand = rung_geom(up);
        cur = rung_geom(cur_rung);
        dwell = (cand.w != cur.w || cand.h != cur.h) ? 64'(r_dwell_rs) : 64'(r_dwell);
        if (now - up_since >= dwell && now - last_change >= dwell) begin
          cur_rung = up;
          last_change = now;
          up_since = '0;
          r.chg = 1'b1;
        end
      end
    end
    cur = rung_geom(cur_rung);
    r.idx = 3'(cur_rung);
    r.w = cur.w[15:0];
    r.h = cur.h[15:0];
    r.fps = cur.fps[7:0];
    r.pct = cur.pct[6:0];
    return r;
  endfunction

  // Sampling at the rising edge: predict on input accept, check on output accept.
  always @(posedge clk) begin
    rung_out_t e;
    rung_out_t got;
    cycles <= cycles + 1;
    in_acc <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) expected_rungs.push_back(next_rung(bitrate_bps, now_us));
      if (out_valid && !out_stall) begin
        got = '{changed, rung_index, frame_width, frame_height, frame_rate, scale_pct};
        if (expected_rungs.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", got);
          errors++;
        end else begin
          e = expected_rungs.pop_front();
          if (got !== e) begin
            if (errors < 10)
              $display("mismatch: chg %b/%b idx %0d/%0d w %0d/%0d h %0d/%0d fps %0d/%0d pct %0d/%0d",
                       e.chg, got.chg, e.idx, got.idx, e.w, got.w, e.h, got.h,
                       e.fps, got.fps, e.pct, got.pct);
            errors++;
          end
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Item driver: a new item goes out only once the previous one has been taken.
  always @(negedge clk) begin
    update_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (pending_updates.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = pending_updates.pop_front();
        in_valid <= 1'b1;
        bitrate_bps <= it.bps;
        now_us <= it.now;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with a long hold-off on request.
  always @(negedge clk) begin
    out_stall <= !rst && (hold_left != 0 || $urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MAX_W: r_w = val[15:0];
      REG_MAX_H: r_h = val[15:0];
      REG_MAX_FPS: r_fps = val[7:0];
      REG_BPP_NUM: r_num = val[15:0];
      REG_BPP_DEN: r_den = val[15:0];
      REG_HEADROOM: r_head = val[7:0];
      REG_DWELL: r_dwell = val;
      REG_DWELL_RS: r_dwell_rs = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_regs(logic [15:0] w, logic [15:0] h, logic [7:0] fps, logic [15:0] num,
                           logic [15:0] den, logic [7:0] head, logic [31:0] dw,
                           logic [31:0] dwr);
    write_reg(REG_MAX_W, 32'(w));
    write_reg(REG_MAX_H, 32'(h));
    write_reg(REG_MAX_FPS, 32'(fps));
    write_reg(REG_BPP_NUM, 32'(num));
    write_reg(REG_BPP_DEN, 32'(den));
    write_reg(REG_HEADROOM, 32'(head));
    write_reg(REG_DWELL, dw);
    write_reg(REG_DWELL_RS, dwr);
  endtask

  function automatic void queue_update(logic [31:0] bps, logic [63:0] now);
    update_t u;
    u.bps = bps;
    u.now = now;
    pending_updates.push_back(u);
  endfunction

  // Bitrates mostly near the headroom threshold of some rung; times mostly advancing.
  function automatic void queue_random_update();
    logic [63:0] v;
    logic [31:0] bps;
    logic [63:0] now;
    case ($urandom_range(0, 9))
      0: bps = $urandom;
      1: bps = '0;
      2: bps = 32'hFFFF_FFFF;
      default: begin
        v = (64'(rung_need($urandom_range(0, 5))) * 64'(r_head) * 64'($urandom_range(85, 115)))
            / 10000;
        bps = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      end
    endcase
    case ($urandom_range(0, 19))
      0: begin
        queue_update(bps, '0);
        return;
      end
      1: clock_us = {$urandom, $urandom};
      2: clock_us = clock_us + 64'($urandom);
      default: clock_us = clock_us + 64'($urandom_range(0, 2500));
    endcase
    now = clock_us;
    queue_update(bps, now);
  endfunction

  task automatic wait_idle();
    while (pending_updates.size() != 0 || in_valid || expected_rungs.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) queue_random_update();
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: defaults with short dwells, drops, the unset time mark and time wrap.
    load_regs(16'd1920, 16'd1080, 8'd60, 16'd1, 16'd10, 8'd120, 32'd1000, 32'd3000);
    queue_update(32'hFFFF_FFFF, 64'd1);
    queue_update(32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_update(32'hFFFF_FFFF, 64'd0);
    queue_update(32'hFFFF_FFFF, 64'd100);
    queue_update(32'hFFFF_FFFF, 64'd4000);
    queue_update(32'hFFFF_FFFF, 64'd4100);
    queue_update(32'hFFFF_FFFF, 64'd9000);
    queue_update(32'hFFFF_FFFF, 64'd9100);
    queue_update(32'hFFFF_FFFF, 64'd20000);
    queue_update(rung_need(2), 64'd20100);
    queue_update(rung_need(2) - 1, 64'd20200);
    queue_update(rung_need(1), 64'd20300);
    queue_update(32'hAAAA_5555, 64'hAAAA_AAAA_5555_5555);
    queue_update(32'h5555_AAAA, 64'h5555_5555_AAAA_AAAA);
    queue_update(rung_need(5) - 1, 64'd30000);
    wait_idle();

    run_phase(0, 0);
    load_regs(16'hFFFF, 16'hFFFF, 8'd0, 16'hFFFF, 16'd1, 8'd255, 32'd0, 32'hFFFF_FFFF);
    run_phase(65, 0);
    load_regs(16'd320, 16'd128, 8'd255, 16'd1, 16'hFFFF, 8'd100, 32'd500, 32'd800);
    @(negedge clk);
    hold_go <= 1'b1;
    @(negedge clk);
    hold_go <= 1'b0;
    run_phase(0, 65);
    load_regs(16'd0, 16'd0, 8'd1, 16'd7, 16'd0, 8'd100, 32'd10, 32'd20);
    run_phase(37, 37);
    load_regs(16'd1280, 16'd720, 8'd30, 16'd3, 16'd20, 8'd150, 32'd1500, 32'd2500);
    run_phase(20, 20);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_rungs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* quality_ladder_rate_adapter_unit.f */
design/qlra_pkg.sv
design/qlra_mul.sv
design/qlra_div.sv
design/quality_ladder_rate_adapter_unit.sv
tb/tb.sv
